>>> hw/rtl/ibfe_pkg.sv
// ibfe_pkg: shared types, constants and the crc_a byte update of the
// iso14443 block frame encoder; no dependencies

package ibfe_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_INITIAL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PCB_BASE    = 2'd1;
	localparam int unsigned CFG_DATA_W = 16;

	// reset values
	localparam logic [15:0] CRC_INITIAL_RESET = 16'h6363;
	localparam logic [7:0]  PCB_BASE_RESET    = 8'h02;

	// frame kinds as sampled on the first byte
	localparam logic KIND_I_BLOCK = 1'b0;

	// default depth of the queue between front and back
	localparam int unsigned IBFE_QUEUE_DEPTH = 4;

	// classified input item
	typedef struct packed {
		logic       needs_pcb;
		logic       first;
		logic       last;
		logic [7:0] data;
	} item_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// live configuration
	typedef struct packed {
		logic [15:0] crc_initial;
		logic [7:0]  pcb_base;
	} cfg_t;

	// iso 14443 crc_a, one byte, reflected
	function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = b ^ crc[7:0];
		c = c ^ {c[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {c, 8'h00} ^ {5'b00000, c, 3'b000} ^ {12'h000, c[7:4]};
	endfunction

endpackage

>>> hw/rtl/ibfe_front.sv
// ibfe_front: accepts input requests, classifies them and holds them in a
// short queue for the back end; depends on ibfe_pkg

module ibfe_front #(
	parameter int unsigned QUEUE_DEPTH = ibfe_pkg::IBFE_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	input  logic          first_byte,
	input  logic          last_byte,
	output ibfe_pkg::head_t head,
	input  logic          head_pop
);
	import ibfe_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	item_t            new_item;
	logic             do_push;
	logic             do_pop;

	// classify: pcb only on the first byte of an i-block
	always_comb begin
		new_item.needs_pcb = first_byte & (kind == KIND_I_BLOCK);
		new_item.first     = first_byte;
		new_item.last      = last_byte;
		new_item.data      = data_byte;
	end

	assign full      = (count_q == CNT_FULL);
	assign do_push   = push & ~full;
	assign do_pop    = head_pop & head.valid;
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// fill count stays in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

	// an empty queue with no push stays empty
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!head.valid && !push) |=> !head.valid)
		else $error("queue filled without a push");

	// pointers meet when the queue is empty
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while empty");

endmodule

>>> hw/rtl/ibfe_back.sv
// ibfe_back: byte sequencer with crc_a register, block toggle and output
// register; depends on ibfe_pkg

module ibfe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ibfe_pkg::cfg_t  cfg,
	input  ibfe_pkg::head_t head,
	output logic            head_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_end
);
	import ibfe_pkg::*;

	// sequencer phases within one item
	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_CRCL = 2'd2;
	localparam logic [1:0] PH_CRCH = 2'd3;

	logic [1:0]  phase_q;
	logic [15:0] crc_q;
	logic        toggle_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_run_last_q;
	logic        out_frame_end_q;

	logic        advance;
	logic        emit_pcb;
	logic [7:0]  pcb;
	logic [15:0] crc_base;
	logic [7:0]  crc_in;
	logic [15:0] crc_next;
	logic [7:0]  nxt_byte;
	logic        nxt_run_last;
	logic        nxt_frame_end;
	logic [1:0]  nxt_phase;
	logic        item_done;

	assign advance  = head.valid & (~out_valid_q | pop);
	assign emit_pcb = (phase_q == PH_HEAD) & head.item.needs_pcb;
	assign pcb      = {cfg.pcb_base[7:1], toggle_q};
	assign crc_base = ((phase_q == PH_HEAD) & head.item.first) ? cfg.crc_initial : crc_q;
	assign crc_in   = emit_pcb ? pcb : head.item.data;
	assign crc_next = crc_a_byte(crc_base, crc_in);

	// select the byte for the current phase
	always_comb begin
		nxt_byte      = head.item.data;
		nxt_run_last  = 1'b0;
		nxt_frame_end = 1'b0;
		nxt_phase     = phase_q;
		item_done     = 1'b0;
		unique case (phase_q)
			PH_HEAD, PH_DATA: begin
				if (emit_pcb) begin
					nxt_byte  = pcb;
					nxt_phase = PH_DATA;
				end else begin
					nxt_byte     = head.item.data;
					nxt_run_last = ~head.item.last;
					item_done    = ~head.item.last;
					nxt_phase    = head.item.last ? PH_CRCL : PH_HEAD;
				end
			end
			PH_CRCL: begin
				nxt_byte  = crc_q[7:0];
				nxt_phase = PH_CRCH;
			end
			PH_CRCH: begin
				nxt_byte      = crc_q[15:8];
				nxt_run_last  = 1'b1;
				nxt_frame_end = 1'b1;
				item_done     = 1'b1;
				nxt_phase     = PH_HEAD;
			end
			default: begin
				nxt_phase = PH_HEAD;
			end
		endcase
	end

	assign head_pop = advance & item_done;

	// sequencer state, crc and toggle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			crc_q    <= CRC_INITIAL_RESET;
			toggle_q <= 1'b0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			if ((phase_q == PH_HEAD) || (phase_q == PH_DATA)) begin
				crc_q <= crc_next;
			end
			if (emit_pcb) begin
				toggle_q <= ~toggle_q;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q      <= nxt_byte;
			out_run_last_q  <= nxt_run_last;
			out_frame_end_q <= nxt_frame_end;
		end
	end

	assign empty     = ~out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = out_run_last_q;
	assign frame_end = out_frame_end_q;

	// crc high only follows crc low
	a_crch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CRCH) |-> ($past(phase_q) == PH_CRCL || $past(phase_q) == PH_CRCH))
		else $error("crc high reached without crc low");

	// toggle flips only when a pcb goes out
	a_toggle_pcb: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(toggle_q) |-> $past(advance && emit_pcb))
		else $error("block toggle changed without a pcb");

	// the item leaves the queue only with its run-last byte
	a_pop_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |=> (out_valid_q && out_run_last_q))
		else $error("item retired without run-last byte");

	// frame end is always the run-last byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_frame_end_q) |-> out_run_last_q)
		else $error("frame end without run-last");

endmodule

>>> hw/rtl/iso14443_block_frame_encoder.sv
// iso14443_block_frame_encoder: top level with configuration registers,
// front queue and back sequencer; depends on ibfe_pkg, ibfe_front, ibfe_back
//
// Usage
//   Input side is a queue: drive kind, data_byte, first_byte, last_byte and
//   push; a request is taken at a clock edge with push high and full low.
//   Result side is a queue too: while empty is low the oldest framed byte
//   is on out_byte, run_last and frame_end; pop takes it.
//   On the first byte of an i-block a pcb byte (pcb_base with bit 0 set from
//   the block toggle) goes out first; after the last byte crc low and crc
//   high follow. Raw frames carry no pcb.
//   The first byte of an item passes through the queue and then the output
//   register before it shows on the outputs. The single sequencer emits one
//   result byte per cycle while the queue holds an item and the output
//   register is free or popped, and does a crc_a update on each pcb or data
//   byte; an item yields 1 to 4 result bytes.
//   Configuration is written through cfg_write, cfg_index, cfg_data, with
//   effect at once; write only while the block is idle (not enforced).
//   Reset clears the queue and output register, loads crc 0x6363 and the
//   register defaults. When the receiver stalls, the output register holds,
//   the queue fills and full rises after QUEUE_DEPTH more requests.

module iso14443_block_frame_encoder #(
	parameter int unsigned QUEUE_DEPTH = ibfe_pkg::IBFE_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             kind,
	input  logic [7:0]                       data_byte,
	input  logic                             first_byte,
	input  logic                             last_byte,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       out_byte,
	output logic                             run_last,
	output logic                             frame_end,
	input  logic                             cfg_write,
	input  logic [ibfe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ibfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ibfe_pkg::*;

	cfg_t  cfg_q;
	head_t head;
	logic  head_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_initial <= CRC_INITIAL_RESET;
			cfg_q.pcb_base    <= PCB_BASE_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_CRC_INITIAL) begin
				cfg_q.crc_initial <= cfg_data[15:0];
			end else if (cfg_index == CFG_PCB_BASE) begin
				cfg_q.pcb_base <= cfg_data[7:0];
			end
		end
	end

	// front: accept and classify
	ibfe_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.data_byte (data_byte),
		.first_byte(first_byte),
		.last_byte (last_byte),
		.head      (head),
		.head_pop  (head_pop)
	);

	// back: framing and crc
	ibfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.head_pop (head_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last),
		.frame_end(frame_end)
	);

endmodule
